### src/grid_astar_path_search_core_defines.svh
// Assertion macros for the checker of the grid path search core.
`ifndef GRID_ASTAR_PATH_SEARCH_CORE_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define GAPS_ASSERT_IMPL(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a signal holds while a transfer is stalled.
`define GAPS_ASSERT_HOLD(name, clk, rstn, vld, rdy, sig, msg) \
    `GAPS_ASSERT_IMPL(name, clk, rstn, vld && !rdy |=> $stable(sig), msg)

`endif

### src/gaps_pkg.sv
package gaps_pkg;

    localparam int GRID_ROWS   = 8;
    localparam int GRID_COLS   = 8;
    localparam int QUEUE_DEPTH = GRID_ROWS * GRID_COLS;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [2:0] cell_row;
        logic [2:0] cell_col;
        logic       walkable;
        logic [2:0] start_row;
        logic [2:0] start_col;
        logic [2:0] goal_row;
        logic [2:0] goal_col;
    } in_item_t;

    typedef struct packed {
        logic [2:0] path_row;
        logic [2:0] path_col;
        logic [6:0] path_length;
        logic       found;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] idx;
        logic [6:0] f;
        logic [5:0] g;
    } entry_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic       active;
        op_t        op;
        logic       shifting;
        logic [5:0] idx;
        logic [6:0] f;
        logic [5:0] g;
    } token_t;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    function automatic logic [3:0] dist_to_goal(logic [5:0] pos, logic [5:0] goal);
        logic [2:0] dr;
        logic [2:0] dc;
        dr = (pos[5:3] > goal[5:3]) ? pos[5:3] - goal[5:3] : goal[5:3] - pos[5:3];
        dc = (pos[2:0] > goal[2:0]) ? pos[2:0] - goal[2:0] : goal[2:0] - pos[2:0];
        return {1'b0, dr} + {1'b0, dc};
    endfunction

    function automatic logic in_grid(logic [2:0] r, logic [2:0] c);
        return (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
    endfunction

endpackage

### src/gaps_cell.sv
module gaps_cell
    import gaps_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   first_cell,
    input  logic   flush,
    input  token_t tok_i,
    input  entry_t right_i,
    output entry_t entry_o,
    output token_t tok_o
);

    entry_t entry_reg, entry_next;
    token_t tok_reg, tok_next;
    logic   place_here;

    always_comb begin
        entry_next = entry_reg;
        tok_next   = '0;
        place_here = tok_i.shifting ||
                     (first_cell ? (entry_reg.f > tok_i.f) :
                      ((entry_reg.f > tok_i.f) ||
                       ((entry_reg.f == tok_i.f) && (entry_reg.g >= tok_i.g))));
        if (tok_i.active) begin
            case (tok_i.op)
                OP_INSERT: begin
                    if (!entry_reg.valid) begin
                        entry_next = {1'b1, tok_i.idx, tok_i.f, tok_i.g};
                    end else if (place_here) begin
                        entry_next = {1'b1, tok_i.idx, tok_i.f, tok_i.g};
                        tok_next   = {1'b1, OP_INSERT, 1'b1, entry_reg.idx, entry_reg.f,
                                      entry_reg.g};
                    end else begin
                        tok_next = tok_i;
                    end
                end
                OP_REMOVE: begin
                    if (tok_i.shifting || (entry_reg.valid && entry_reg.idx == tok_i.idx)) begin
                        entry_next = right_i;
                        if (right_i.valid) begin
                            tok_next = {1'b1, OP_REMOVE, 1'b1, tok_i.idx, tok_i.f, tok_i.g};
                        end
                    end else if (entry_reg.valid) begin
                        tok_next = tok_i;
                    end
                end
                default: begin
                    tok_next = '0;
                end
            endcase
        end
        if (flush) begin
            entry_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end else begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign entry_o = entry_reg;
    assign tok_o   = tok_reg;

endmodule

### src/gaps_queue.sv
module gaps_queue
    import gaps_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   flush,
    input  token_t tok_i,
    output entry_t head_o,
    output logic   busy_o
);

    entry_t                 entry_w [QUEUE_DEPTH];
    token_t                 tok_w   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] active_w;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        token_t tok_in;
        entry_t right_in;

        if (i == 0) begin : g_first
            assign tok_in = tok_i;
        end else begin : g_rest
            assign tok_in = tok_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_in = '0;
        end else begin : g_body
            assign right_in = entry_w[i+1];
        end

        gaps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .first_cell (i == 0),
            .flush      (flush),
            .tok_i      (tok_in),
            .right_i    (right_in),
            .entry_o    (entry_w[i]),
            .tok_o      (tok_w[i])
        );

        assign active_w[i] = tok_w[i].active;
    end

    assign head_o = entry_w[0];
    assign busy_o = |active_w;

endmodule

### src/grid_astar_path_search_core.sv
// Grid path search core. The input channel (s_valid, s_ready, s_data) takes two kinds of
// transfer: mode 0 writes one walkable bit of the 8 x 8 map, mode 1 runs
// an A* search from the start cell to the goal cell. The result channel (m_valid, m_ready,
// m_data) returns the path cells from start to goal, one transfer per cell with last set on
// the goal, or one transfer with found cleared when there is no path.
// The open queue is a row of 64 cells; each insertion or removal runs as a token that moves
// one cell per cycle, and the core waits until the queue is no longer busy before going on.
// The time a search takes is set by the number of cells expanded and the queue length; tracing
// the path back reads the stored direction and writes each path cell, and emitting reads each
// path cell and loads it into the output register.
// A new item is accepted only while no search is running; a map load is accepted while an
// earlier result still waits in the output register. When the receiver stalls, the core
// holds the result and waits before producing the next one.
// Reset marks every map cell as blocked, empties the queue and clears the output valid flag.
module grid_astar_path_search_core
    import gaps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_POP      = 11'b00000000010,
        S_NB       = 11'b00000000100,
        S_CMP      = 11'b00000001000,
        S_REINS    = 11'b00000010000,
        S_WAIT     = 11'b00000100000,
        S_TRACE_RD = 11'b00001000000,
        S_TRACE_WR = 11'b00010000000,
        S_EMIT_RD  = 11'b00100000000,
        S_EMIT_LD  = 11'b01000000000,
        S_NOPATH   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next, ret_reg, ret_next;
    logic [5:0] goal_reg, goal_next, cur_reg, cur_next, gcur_reg, gcur_next;
    logic [5:0] n_reg, n_next, ng_reg, ng_next, tcell_reg, tcell_next;
    logic [1:0] d_reg, d_next;
    logic [6:0] count_reg, count_next, len_reg, len_next;
    logic [6:0] tk_reg, tk_next, ek_reg, ek_next;
    logic [63:0] map_reg, map_next, open_reg, open_next, closed_reg, closed_next;
    token_t     issue_reg, issue_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    logic [5:0] g_mem [64];
    logic [1:0] dir_mem [64];
    logic [5:0] path_mem [64];
    logic [5:0] g_rd_reg, path_rd_reg;
    logic [1:0] dir_rd_reg;
    logic       g_we, path_we;
    logic [5:0] g_waddr, g_wdata, path_waddr, path_wdata;
    logic [1:0] dir_wdata;

    entry_t     head;
    logic       q_busy, flush, accept, out_free, search_ok, emit_last;
    logic [5:0] start_cell, in_goal, nb, ng, step_cell;
    logic [2:0] r, c, nr, nc, tr, tc;
    logic       nb_ok;
    logic [6:0] nb_f;

    gaps_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flush   (flush),
        .tok_i   (issue_reg),
        .head_o  (head),
        .busy_o  (q_busy)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign start_cell = {s_data.start_row, s_data.start_col};
    assign in_goal    = {s_data.goal_row, s_data.goal_col};
    assign search_ok  = in_grid(s_data.start_row, s_data.start_col) &&
                        in_grid(s_data.goal_row, s_data.goal_col) &&
                        map_reg[start_cell] && map_reg[in_goal] && (start_cell != in_goal);

    assign r  = cur_reg[5:3];
    assign c  = cur_reg[2:0];
    assign ng = gcur_reg + 6'd1;

    always_comb begin
        nr    = r;
        nc    = c;
        nb_ok = 1'b0;
        case (d_reg)
            DIR_UP: begin
                nb_ok = (r != 3'd0);
                nr    = r - 3'd1;
            end
            DIR_RIGHT: begin
                nb_ok = (int'(c) + 1 < GRID_COLS);
                nc    = c + 3'd1;
            end
            DIR_DOWN: begin
                nb_ok = (int'(r) + 1 < GRID_ROWS);
                nr    = r + 3'd1;
            end
            DIR_LEFT: begin
                nb_ok = (c != 3'd0);
                nc    = c - 3'd1;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign nb   = {nr, nc};
    assign nb_f = {1'b0, ng} + {3'b000, dist_to_goal(nb, goal_reg)};

    assign tr = tcell_reg[5:3];
    assign tc = tcell_reg[2:0];
    always_comb begin
        step_cell = tcell_reg;
        case (dir_rd_reg)
            DIR_UP:    step_cell = {tr + 3'd1, tc};
            DIR_RIGHT: step_cell = {tr, tc - 3'd1};
            DIR_DOWN:  step_cell = {tr - 3'd1, tc};
            DIR_LEFT:  step_cell = {tr, tc + 3'd1};
            default:   step_cell = tcell_reg;
        endcase
    end

    assign emit_last = (ek_reg + 7'd1 == len_reg);

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        goal_next    = goal_reg;
        cur_next     = cur_reg;
        gcur_next    = gcur_reg;
        n_next       = n_reg;
        ng_next      = ng_reg;
        tcell_next   = tcell_reg;
        d_next       = d_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        tk_next      = tk_reg;
        ek_next      = ek_reg;
        map_next     = map_reg;
        open_next    = open_reg;
        closed_next  = closed_reg;
        issue_next   = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        flush        = 1'b0;
        g_we         = 1'b0;
        g_waddr      = nb;
        g_wdata      = ng;
        dir_wdata    = d_reg;
        path_we      = 1'b0;
        path_waddr   = tk_reg[5:0] - 6'd1;
        path_wdata   = tcell_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.mode == MODE_LOAD) begin
                        if (in_grid(s_data.cell_row, s_data.cell_col)) begin
                            map_next[{s_data.cell_row, s_data.cell_col}] = s_data.walkable;
                        end
                    end else begin
                        goal_next = in_goal;
                        if (search_ok) begin
                            flush                   = 1'b1;
                            open_next               = '0;
                            closed_next             = '0;
                            open_next[start_cell]   = 1'b1;
                            issue_next              = {1'b1, OP_INSERT, 1'b0, start_cell,
                                                       {3'b000, dist_to_goal(start_cell, in_goal)},
                                                       6'd0};
                            count_next              = 7'd1;
                            ret_next                = S_POP;
                            state_next              = S_WAIT;
                        end else begin
                            state_next = S_NOPATH;
                        end
                    end
                end
            end
            S_POP: begin
                if (count_reg == 7'd0) begin
                    state_next = S_NOPATH;
                end else begin
                    issue_next            = {1'b1, OP_REMOVE, 1'b0, head.idx, head.f, head.g};
                    cur_next              = head.idx;
                    gcur_next             = head.g;
                    open_next[head.idx]   = 1'b0;
                    closed_next[head.idx] = 1'b1;
                    count_next            = count_reg - 7'd1;
                    d_next                = DIR_UP;
                    ret_next              = S_NB;
                    state_next            = S_WAIT;
                end
            end
            S_NB: begin
                n_next  = nb;
                ng_next = ng;
                d_next  = d_reg + 2'd1;
                if (!nb_ok || !map_reg[nb] || closed_reg[nb]) begin
                    state_next = (d_reg == DIR_LEFT) ? S_POP : S_NB;
                end else if (!open_reg[nb]) begin
                    g_we          = 1'b1;
                    issue_next    = {1'b1, OP_INSERT, 1'b0, nb, nb_f, ng};
                    open_next[nb] = 1'b1;
                    count_next    = count_reg + 7'd1;
                    state_next    = S_WAIT;
                    if (nb == goal_reg) begin
                        len_next   = {1'b0, ng} + 7'd1;
                        tk_next    = {1'b0, ng} + 7'd1;
                        tcell_next = nb;
                        ret_next   = S_TRACE_RD;
                    end else begin
                        ret_next = (d_reg == DIR_LEFT) ? S_POP : S_NB;
                    end
                end else begin
                    d_next     = d_reg;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                d_next = d_reg + 2'd1;
                if (g_rd_reg > ng_reg) begin
                    g_we       = 1'b1;
                    g_waddr    = n_reg;
                    g_wdata    = ng_reg;
                    issue_next = {1'b1, OP_REMOVE, 1'b0, n_reg, 7'd0, 6'd0};
                    d_next     = d_reg;
                    ret_next   = S_REINS;
                    state_next = S_WAIT;
                end else begin
                    state_next = (d_reg == DIR_LEFT) ? S_POP : S_NB;
                end
            end
            S_REINS: begin
                issue_next = {1'b1, OP_INSERT, 1'b0, n_reg,
                              {1'b0, ng_reg} + {3'b000, dist_to_goal(n_reg, goal_reg)}, ng_reg};
                d_next     = d_reg + 2'd1;
                ret_next   = (d_reg == DIR_LEFT) ? S_POP : S_NB;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!issue_reg.active && !q_busy) begin
                    state_next = ret_reg;
                end
            end
            S_TRACE_RD: begin
                state_next = S_TRACE_WR;
            end
            S_TRACE_WR: begin
                path_we    = 1'b1;
                tcell_next = step_cell;
                tk_next    = tk_reg - 7'd1;
                if (tk_reg == 7'd1) begin
                    ek_next    = 7'd0;
                    state_next = S_EMIT_RD;
                end else begin
                    state_next = S_TRACE_RD;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {path_rd_reg[5:3], path_rd_reg[2:0], len_reg, 1'b1, emit_last};
                    ek_next      = ek_reg + 7'd1;
                    state_next   = emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_NOPATH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, 3'd0, 7'd0, 1'b0, 1'b1};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (g_we) begin
            g_mem[g_waddr]   <= g_wdata;
            dir_mem[g_waddr] <= dir_wdata;
        end
        g_rd_reg   <= g_mem[nb];
        dir_rd_reg <= dir_mem[tcell_reg];
    end

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rd_reg <= path_mem[ek_reg[5:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            count_reg   <= '0;
            map_reg     <= '0;
            open_reg    <= '0;
            closed_reg  <= '0;
            issue_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            count_reg   <= count_next;
            map_reg     <= map_next;
            open_reg    <= open_next;
            closed_reg  <= closed_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        goal_reg   <= goal_next;
        cur_reg    <= cur_next;
        gcur_reg   <= gcur_next;
        n_reg      <= n_next;
        ng_reg     <= ng_next;
        tcell_reg  <= tcell_next;
        d_reg      <= d_next;
        len_reg    <= len_next;
        tk_reg     <= tk_next;
        ek_reg     <= ek_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/gaps_checker.sv
`include "grid_astar_path_search_core_defines.svh"

module gaps_checker
    import gaps_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `GAPS_ASSERT_IMPL(a_m_valid_held, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result transfer dropped while stalled")
    `GAPS_ASSERT_HOLD(a_m_data_held, aclk, aresetn, m_valid, m_ready, m_data, "result payload changed while stalled")
    `GAPS_ASSERT_IMPL(a_no_path_shape, aclk, aresetn, m_valid && !m_data.found |-> m_data.last && m_data.path_length == 7'd0 && m_data.path_row == 3'd0 && m_data.path_col == 3'd0, "no-path result malformed")
    `GAPS_ASSERT_IMPL(a_path_length, aclk, aresetn, m_valid && m_data.found |-> m_data.path_length >= 7'd2, "path shorter than two cells")
    `GAPS_ASSERT_IMPL(a_search_busy, aclk, aresetn, s_valid && s_ready && s_data.mode |=> !s_ready, "search accepted without leaving idle")

endmodule

bind grid_astar_path_search_core gaps_checker u_gaps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
